[sv/ffca_pkg.sv]
package ffca_pkg;

    // Default pool geometry.
    localparam int POOL_CELLS_DEF  = 1024;
    localparam int MAX_RECORDS_DEF = 64;

    // Cells held in one word of the occupancy memory.
    localparam int WORD_BITS = 8;

    // Fixed field widths of the request and response beats.
    localparam int LEN_W  = 11;
    localparam int ADDR_W = 10;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [LEN_W-1:0]  run_length;
        logic [ADDR_W-1:0] start_address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted_address;
        logic [LEN_W-1:0]  free_cells;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MSCAN,
        S_TSCAN,
        S_TWRITE,
        S_MRD,
        S_MWR,
        S_DONE
    } t_state;

endpackage

[sv/ffca_ram.sv]
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/first_fit_cell_allocator_unit.sv]
// A zero length, full table or oversize allocate answers with no scan; an allocate scans
// the map, then the table, and a free scans the table, before the table and map writes.
// One request at a time; the map scan reads one 8-cell word per cycle
// and the record search one table entry per cycle.
// Reset (synchronous, active low) starts a clearing pass over the map words and
// table entries with busy high; the result strobe cannot be stalled.
module first_fit_cell_allocator_unit
    import ffca_pkg::*;
#(
    parameter int POOL_CELLS  = POOL_CELLS_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int NW    = POOL_CELLS / WORD_BITS;
    localparam int WAW   = $clog2(NW);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int CW    = $clog2(POOL_CELLS);
    localparam int LW    = $clog2(POOL_CELLS + 1);
    localparam int RW    = $clog2(MAX_RECORDS);
    localparam int KW    = $clog2(MAX_RECORDS + 1);
    localparam int CLR_N = (NW > MAX_RECORDS) ? NW : MAX_RECORDS;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int SW    = ((WAW > RW) ? WAW : RW) + 1;
    localparam int REC_W = 1 + CW + LW;

    typedef struct packed {
        logic          valid;
        logic [CW-1:0] start;
        logic [LW-1:0] length;
    } t_rec;

    t_state r_state, n_state;
    logic [CLRW-1:0]   r_clr, n_clr;
    logic [SW-1:0]     r_ridx, n_ridx;
    logic [SW-1:0]     r_pidx, n_pidx;
    logic              r_dv, n_dv;
    logic [LW-1:0]     r_run, n_run;
    logic [LW-1:0]     r_want, n_want;
    t_cmd              r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CW-1:0]     r_first, n_first;
    logic [RW-1:0]     r_slot, n_slot;
    logic [LW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [WAW-1:0]    r_widx, n_widx;
    logic [LW-1:0]     r_free, n_free;
    logic [KW-1:0]     r_live, n_live;
    t_rsp              r_rsp, n_rsp;

    logic                 map_wr_en, map_rd_en;
    logic [WAW-1:0]       map_wr_addr, map_rd_addr;
    logic [WORD_BITS-1:0] map_wr_data, map_rd_data, cell_mask;
    logic                 tab_wr_en, tab_rd_en;
    logic [RW-1:0]        tab_wr_addr, tab_rd_addr;
    logic [REC_W-1:0]     tab_wr_data, tab_rd_data;

    logic          m_hit;
    logic [LW-1:0] m_run;
    logic [BW-1:0] m_pos;
    logic [CW-1:0] m_first;
    t_rec          t_rd;
    logic          t_hit;
    logic          issue;

    // Occupancy map: one bit per cell, eight cells a word.
    ffca_ram #(.WIDTH(WORD_BITS), .DEPTH(NW)) u_map (
        .i_clk    (i_clk),
        .i_wr_en  (map_wr_en),
        .i_wr_addr(map_wr_addr),
        .i_wr_data(map_wr_data),
        .i_rd_en  (map_rd_en),
        .i_rd_addr(map_rd_addr),
        .o_rd_data(map_rd_data)
    );

    // Allocation table: valid, start and length per record.
    ffca_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_tab (
        .i_clk    (i_clk),
        .i_wr_en  (tab_wr_en),
        .i_wr_addr(tab_wr_addr),
        .i_wr_data(tab_wr_data),
        .i_rd_en  (tab_rd_en),
        .i_rd_addr(tab_rd_addr),
        .o_rd_data(tab_rd_data)
    );

    // Run counting over one returned map word, carrying the run from earlier words.
    always_comb begin
        m_run = r_run;
        m_hit = 1'b0;
        m_pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (!m_hit) begin
                if (map_rd_data[b]) begin
                    m_run = '0;
                end else begin
                    m_run = m_run + 1'b1;
                    if (m_run == r_want) begin
                        m_hit = 1'b1;
                        m_pos = BW'(b);
                    end
                end
            end
        end
        m_first = CW'(int'(r_pidx[WAW-1:0]) * WORD_BITS + int'(m_pos) + 1 - int'(r_want));
    end

    // Record check: a free slot for an allocate, a matching start for a free.
    always_comb begin
        t_rd = t_rec'(tab_rd_data);
        if (r_cmd == CMD_ALLOC) begin
            t_hit = !t_rd.valid;
        end else begin
            t_hit = t_rd.valid && (32'(t_rd.start) == 32'(r_addr));
        end
    end

    // Cells of the current word that fall inside the run being written.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            cell_mask[b] = (int'(r_widx) * WORD_BITS + b >= int'(r_lo)) &&
                           (int'(r_widx) * WORD_BITS + b <= int'(r_hi));
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) == CLR_N - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_req.cmd == CMD_FREE) begin
                        n_state = S_TSCAN;
                    end else if (i_req.run_length == '0 ||
                                 32'(r_live) >= MAX_RECORDS ||
                                 32'(i_req.run_length) > POOL_CELLS) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MSCAN;
                    end
                end
            end
            S_MSCAN: begin
                if (r_dv) begin
                    if (m_hit) begin
                        n_state = S_TSCAN;
                    end else if (32'(r_pidx) == NW - 1) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TSCAN: begin
                if (r_dv) begin
                    if (t_hit) begin
                        n_state = S_TWRITE;
                    end else if (32'(r_pidx) == MAX_RECORDS - 1) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TWRITE: n_state = S_MRD;
            S_MRD:    n_state = S_MWR;
            // Each further word of the run needs a fresh read before its write.
            S_MWR: begin
                if (r_widx == r_hi[CW-1:BW]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath updates and memory port control.
    always_comb begin
        n_clr   = r_clr;
        n_ridx  = r_ridx;
        n_pidx  = r_ridx;
        n_run   = r_run;
        n_want  = r_want;
        n_cmd   = r_cmd;
        n_addr  = r_addr;
        n_first = r_first;
        n_slot  = r_slot;
        n_len   = r_len;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_widx  = r_widx;
        n_free  = r_free;
        n_live  = r_live;
        n_rsp   = r_rsp;

        issue = ((r_state == S_MSCAN) && (32'(r_ridx) < NW)) ||
                ((r_state == S_TSCAN) && (32'(r_ridx) < MAX_RECORDS));
        n_dv  = issue && (n_state == r_state);

        map_wr_en   = 1'b0;
        map_wr_addr = r_widx;
        map_wr_data = '0;
        map_rd_en   = 1'b0;
        map_rd_addr = r_widx;
        tab_wr_en   = 1'b0;
        tab_wr_addr = r_slot;
        tab_wr_data = '0;
        tab_rd_en   = 1'b0;
        tab_rd_addr = RW'(r_ridx);

        unique case (r_state)
            S_CLEAR: begin
                n_clr       = r_clr + 1'b1;
                map_wr_en   = (32'(r_clr) < NW);
                map_wr_addr = WAW'(r_clr);
                tab_wr_en   = (32'(r_clr) < MAX_RECORDS);
                tab_wr_addr = RW'(r_clr);
            end
            S_IDLE: begin
                n_cmd  = i_req.cmd;
                n_want = LW'(i_req.run_length);
                n_addr = i_req.start_address;
                n_ridx = '0;
                n_run  = '0;
                n_rsp.granted_address = '0;
                n_rsp.free_cells      = LEN_W'(r_free);
                if (32'(r_live) >= MAX_RECORDS && i_req.run_length != '0) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_NO_FIT;
                end
            end
            S_MSCAN: begin
                map_rd_en   = issue;
                map_rd_addr = WAW'(r_ridx);
                if (issue) begin
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_dv) begin
                    n_run = m_run;
                    if (m_hit) begin
                        n_first = m_first;
                        n_ridx  = '0;
                    end
                end
                n_rsp.status = ST_NO_FIT;
            end
            S_TSCAN: begin
                tab_rd_en = issue;
                if (issue) begin
                    n_ridx = r_ridx + 1'b1;
                end
                if (r_dv && t_hit) begin
                    n_slot = r_pidx[RW-1:0];
                    if (r_cmd == CMD_ALLOC) begin
                        n_lo  = r_first;
                        n_len = r_want;
                    end else begin
                        n_lo  = t_rd.start;
                        n_len = t_rd.length;
                    end
                end
                n_rsp.status = (r_cmd == CMD_ALLOC) ? ST_FULL : ST_UNKNOWN;
            end
            S_TWRITE: begin
                tab_wr_en = 1'b1;
                if (r_cmd == CMD_ALLOC) begin
                    tab_wr_data = REC_W'({1'b1, r_lo, r_len});
                end
                n_hi   = CW'(int'(r_lo) + int'(r_len) - 1);
                n_widx = r_lo[CW-1:BW];
            end
            S_MRD: begin
                map_rd_en = 1'b1;
            end
            S_MWR: begin
                map_wr_en   = 1'b1;
                map_wr_data = (r_cmd == CMD_ALLOC) ? (map_rd_data | cell_mask)
                                                   : (map_rd_data & ~cell_mask);
                n_widx = r_widx + 1'b1;
                if (r_widx == r_hi[CW-1:BW]) begin
                    n_rsp.status = ST_OK;
                    if (r_cmd == CMD_ALLOC) begin
                        n_free = r_free - r_len;
                        n_live = r_live + 1'b1;
                        n_rsp.granted_address = ADDR_W'(r_lo);
                    end else begin
                        n_free = r_free + r_len;
                        n_live = r_live - 1'b1;
                        n_rsp.granted_address = '0;
                    end
                    n_rsp.free_cells = LEN_W'(n_free);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dv    <= 1'b0;
            r_free  <= LW'(POOL_CELLS);
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_dv    <= n_dv;
            r_free  <= n_free;
            r_live  <= n_live;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ridx  <= n_ridx;
        r_pidx  <= n_pidx;
        r_run   <= n_run;
        r_want  <= n_want;
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_first <= n_first;
        r_slot  <= n_slot;
        r_len   <= n_len;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_widx  <= n_widx;
        r_rsp   <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    // A result beat is followed by a ready block.
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after a result beat");

    // The free count never exceeds the pool.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= POOL_CELLS)
        else $error("free count above pool size");

    // The live record count never exceeds the table.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= MAX_RECORDS)
        else $error("live record count above table size");

    // An allocation only marks cells that were free.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MWR && r_cmd == CMD_ALLOC) |-> ((map_rd_data & cell_mask) == '0))
        else $error("allocation overlaps cells in use");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import ffca_pkg::*;
();

    localparam int POOL = POOL_CELLS_DEF;
    localparam int RECS = MAX_RECORDS_DEF;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    first_fit_cell_allocator_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow copy of the pool and the record table.
    bit            cell_used [POOL];
    bit            rec_valid [RECS];
    int unsigned   rec_start [RECS];
    int unsigned   rec_len   [RECS];
    int unsigned   free_cnt;
    int unsigned   live_cnt;
    t_rsp          rsp_queue [$];
    int unsigned   live_starts [$];
    int            errors;
    int            idle_pct;

    // Directed stimulus; the check column is used only where the answer is obvious.
    typedef struct {
        t_req req;
        bit   has_rsp;
        t_rsp rsp;
    } t_row;

    t_row dir_rows [$];

    function automatic t_rsp predict_allocation(t_req req);
        t_rsp        r;
        int unsigned len;
        int unsigned run;
        int          first;
        int          slot;
        r = '{status: ST_OK, granted_address: '0, free_cells: '0};
        len = 32'(req.run_length);
        first = -1;
        slot = -1;
        if (req.cmd == CMD_ALLOC) begin
            if (len == 0) begin
                r.status = ST_NO_FIT;
            end else if (live_cnt >= RECS) begin
                r.status = ST_FULL;
            end else begin
                run = 0;
                if (len <= POOL) begin
                    for (int i = 0; i < POOL; i++) begin
                        run = cell_used[i] ? 0 : run + 1;
                        if (run == len) begin
                            first = i + 1 - len;
                            break;
                        end
                    end
                end
                if (first < 0) begin
                    r.status = ST_NO_FIT;
                end else begin
                    for (int k = 0; k < RECS; k++) begin
                        if (!rec_valid[k]) begin
                            slot = k;
                            break;
                        end
                    end
                    rec_valid[slot] = 1'b1;
                    rec_start[slot] = first;
                    rec_len[slot] = len;
                    for (int i = first; i < first + len; i++) cell_used[i] = 1'b1;
                    free_cnt -= len;
                    live_cnt++;
                    live_starts.push_back(first);
                    r.granted_address = ADDR_W'(first);
                end
            end
        end else begin
            r.status = ST_UNKNOWN;
            for (int k = 0; k < RECS; k++) begin
                if (rec_valid[k] && rec_start[k] == req.start_address) begin
                    for (int i = rec_start[k]; i < rec_start[k] + rec_len[k]; i++)
                        cell_used[i] = 1'b0;
                    free_cnt += rec_len[k];
                    rec_valid[k] = 1'b0;
                    live_cnt--;
                    foreach (live_starts[j]) begin
                        if (live_starts[j] == rec_start[k]) begin
                            live_starts.delete(j);
                            break;
                        end
                    end
                    r.status = ST_OK;
                    break;
                end
            end
        end
        r.free_cells = free_cnt[LEN_W-1:0];
        return r;
    endfunction

    // Drive one beat once the block is free, after an optional random gap.
    task automatic send_beat(t_req req, bit has_rsp, t_rsp rsp);
        t_rsp pred;
        @(posedge i_clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge i_clk);
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = predict_allocation(req);
        if (has_rsp && pred != rsp) begin
            $display("%0t: table row disagrees, expected %p got %p", $time, rsp, pred);
            errors++;
        end
        rsp_queue.push_back(pred);
        start <= 1'b0;
    endtask

    // Response checker; a beat is taken at each edge that ends a strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: unexpected beat, expected none got %p", $time, o_rsp);
                errors++;
            end else begin
                t_rsp e;
                e = rsp_queue.pop_front();
                if (o_rsp.status !== e.status)
                    $display("%0t: status expected %s got %0d", $time, e.status.name(),
                             o_rsp.status);
                if (o_rsp.granted_address !== e.granted_address)
                    $display("%0t: granted_address expected %0d got %0d", $time,
                             e.granted_address, o_rsp.granted_address);
                if (o_rsp.free_cells !== e.free_cells)
                    $display("%0t: free_cells expected %0d got %0d", $time,
                             e.free_cells, o_rsp.free_cells);
                if (o_rsp !== e) errors++;
            end
        end
    end

    function automatic t_req mk(t_cmd c, int unsigned len, int unsigned addr);
        t_req r;
        r.cmd = c;
        r.run_length = LEN_W'(len);
        r.start_address = ADDR_W'(addr);
        return r;
    endfunction

    function automatic t_rsp rs(t_status s, int unsigned g, int unsigned f);
        t_rsp r;
        r.status = s;
        r.granted_address = ADDR_W'(g);
        r.free_cells = LEN_W'(f);
        return r;
    endfunction

    task automatic wait_drain();
        int guard;
        guard = 0;
        while (rsp_queue.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: small allocations and frees of live runs.
    task automatic random_phase(int n, int pct);
        t_req req;
        int   pick;
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                req = mk(CMD_ALLOC, $urandom_range(1, 40), $urandom_range(1023));
            end else if (pick < 50) begin
                req = mk(CMD_ALLOC, $urandom_range(0, 2047), $urandom_range(1023));
            end else if (pick < 88 && live_starts.size() != 0) begin
                req = mk(CMD_FREE, $urandom_range(2047),
                         live_starts[$urandom_range(live_starts.size() - 1)]);
            end else begin
                req = mk(CMD_FREE, $urandom_range(2047), $urandom_range(1023));
            end
            send_beat(req, 1'b0, '0);
        end
    endtask

    initial begin
        t_rsp dummy;
        errors = 0;
        idle_pct = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        free_cnt = POOL;
        live_cnt = 0;
        dummy = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Table: zero length, oversize, whole pool, unknown free.
        dir_rows.push_back('{mk(CMD_ALLOC, 0, 1023), 1, rs(ST_NO_FIT, 0, 1024)});
        dir_rows.push_back('{mk(CMD_ALLOC, 2047, 0), 1, rs(ST_NO_FIT, 0, 1024)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1025, 0), 1, rs(ST_NO_FIT, 0, 1024)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 0), 1, rs(ST_UNKNOWN, 0, 1024)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1024, 0), 1, rs(ST_OK, 0, 0)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1, 0), 1, rs(ST_NO_FIT, 0, 0)});
        dir_rows.push_back('{mk(CMD_FREE, 2047, 0), 1, rs(ST_OK, 0, 1024)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1, 1023), 1, rs(ST_OK, 0, 1023)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1022, 0), 1, rs(ST_OK, 1, 1)});
        dir_rows.push_back('{mk(CMD_ALLOC, 1, 0), 1, rs(ST_OK, 1023, 0)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 1023), 1, rs(ST_OK, 0, 1)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 1023), 1, rs(ST_UNKNOWN, 0, 1)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 1), 1, rs(ST_OK, 0, 1023)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 0), 1, rs(ST_OK, 0, 1024)});
        dir_rows.push_back('{mk(CMD_FREE, 0, 682), 1, rs(ST_UNKNOWN, 0, 1024)});
        dir_rows.push_back('{mk(CMD_ALLOC, 3, 341), 0, dummy});
        dir_rows.push_back('{mk(CMD_ALLOC, 5, 0), 0, dummy});
        dir_rows.push_back('{mk(CMD_FREE, 1365, 0), 0, dummy});
        dir_rows.push_back('{mk(CMD_ALLOC, 2, 0), 0, dummy});
        dir_rows.push_back('{mk(CMD_ALLOC, 4, 0), 0, dummy});
        foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].has_rsp, dir_rows[i].rsp);
        wait_drain();

        // Fill the table with single cells, then ask once more for a full-table answer.
        while (live_cnt < RECS) send_beat(mk(CMD_ALLOC, 1, 0), 1'b0, dummy);
        send_beat(mk(CMD_ALLOC, 1, 0), 1'b1, rs(ST_FULL, 0, free_cnt));
        while (live_starts.size() != 0)
            send_beat(mk(CMD_FREE, 0, live_starts[0]), 1'b0, dummy);
        wait_drain();

        random_phase(350, 0);
        random_phase(300, 84);
        wait_drain();
        random_phase(300, 36);
        random_phase(300, 0);
        wait_drain();

        // Every accepted beat must have produced its result.
        if (rsp_queue.size() != 0) begin
            $display("%0t: missing beats, expected %0d more got none", $time,
                     rsp_queue.size());
            errors++;
        end

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
